// ===== src/tpph_pkg.sv =====
// ---------------------------------------------------------------------------
// tpph_pkg: shared types and constants for the pulse-height analyser
// Job record passed from the front end to the back end, and opcodes.
// ---------------------------------------------------------------------------
package tpph_pkg;

  localparam int unsigned ChannelsDefault = 8;
  localparam int unsigned HistBinsDefault = 4096;
  localparam logic [15:0] MinStart        = 16'd65500;
  localparam logic [16:0] TraceLenReset   = 17'd256;
  localparam logic [16:0] LeadReset       = 17'd16;
  localparam logic [16:0] TailReset       = 17'd16;
  localparam int unsigned QueueDepth      = 4;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_TRACE_LENGTH = 2'd0,
    REG_LEAD_WINDOW  = 2'd1,
    REG_TAIL_WINDOW  = 2'd2
  } reg_idx_t;

  // One job for the back end: a finished trace or a bin read.
  typedef struct packed {
    op_t         op;
    logic [2:0]  channel;
    logic [11:0] bin_index;
    logic [31:0] sum;
    logic [17:0] divisor;
    logic [15:0] max_val;
    logic [15:0] min_val;
  } job_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_CLEAR,
    BE_DIV,
    BE_PICK,
    BE_READ,
    BE_WRITE,
    BE_OUT
  } be_state_t;

endpackage

// ===== src/tpph_ram.sv =====
// ---------------------------------------------------------------------------
// tpph_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module tpph_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== src/tpph_front.sv =====
// ---------------------------------------------------------------------------
// tpph_front: sample accumulator
// Tracks min/max and the pedestal window sum; emits a job at trace end or
// for each bin read.
// ---------------------------------------------------------------------------
module tpph_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [2:0]           channel,
  input  logic [15:0]          sample,
  input  logic [11:0]          bin_index,
  input  logic [16:0]          trace_length,
  input  logic [16:0]          lead_window,
  input  logic [16:0]          tail_window,
  output logic                 job_valid,
  input  logic                 job_ready,
  output tpph_pkg::job_t       job
);
  import tpph_pkg::*;

  logic [16:0] sample_index;
  logic [31:0] window_sum;
  logic [15:0] running_max;
  logic [15:0] running_min;

  logic        take;
  logic        in_win;
  logic        last;
  logic [32:0] sum_wide;
  logic [31:0] sum_next;
  logic [15:0] max_next;
  logic [15:0] min_next;

  assign in_ready = job_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    in_win   = (sample_index < lead_window) ||
               ({1'b0, sample_index} + {1'b0, tail_window} >= {1'b0, trace_length});
    last     = ({1'b0, sample_index} + 18'd1) >= {1'b0, trace_length};
    sum_wide = {1'b0, window_sum} + {17'd0, sample};
    sum_next = in_win ? (sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0]) : window_sum;
    max_next = (sample > running_max) ? sample : running_max;
    min_next = (sample < running_min) ? sample : running_min;
  end

  always_comb begin
    job.op        = op_t'(op);
    job.channel   = channel;
    job.bin_index = bin_index;
    job.sum       = sum_next;
    job.divisor   = {1'b0, lead_window} + {1'b0, tail_window};
    job.max_val   = max_next;
    job.min_val   = min_next;
    job_valid     = in_valid && ((op == OP_READ) || last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      window_sum   <= '0;
      running_max  <= '0;
      running_min  <= MinStart;
    end else if (take && op == OP_SAMPLE) begin
      if (last) begin
        sample_index <= '0;
        window_sum   <= '0;
        running_max  <= '0;
        running_min  <= MinStart;
      end else begin
        sample_index <= sample_index + 17'd1;
        window_sum   <= sum_next;
        running_max  <= max_next;
        running_min  <= min_next;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    job_valid |-> in_valid)
    else $error("job without input");
  assert property (@(posedge clk) disable iff (rst)
    (take && op == OP_SAMPLE && !last) |=> (sample_index == $past(sample_index) + 17'd1))
    else $error("sample index did not advance");
  assert property (@(posedge clk) disable iff (rst)
    running_min <= MinStart)
    else $error("minimum above its start value");
endmodule

// ===== src/tpph_queue.sv =====
// ---------------------------------------------------------------------------
// tpph_queue: small job FIFO
// Decouples the sample front end from the histogram back end.
// ---------------------------------------------------------------------------
module tpph_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           not_full,
  input  tpph_pkg::job_t wdata,
  input  logic           pop,
  output logic           not_empty,
  output tpph_pkg::job_t rdata
);
  import tpph_pkg::*;

  localparam int unsigned Aw = $clog2(QueueDepth);

  job_t        slots [QueueDepth];
  logic [Aw-1:0] wr_ptr;
  logic [Aw-1:0] rd_ptr;
  logic [Aw:0]   fill;

  assign not_full  = fill != (Aw+1)'(QueueDepth);
  assign not_empty = fill != '0;
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && not_full) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && not_full) wr_ptr <= wr_ptr + Aw'(1);
      if (pop && not_empty) rd_ptr <= rd_ptr + Aw'(1);
      fill <= fill + (Aw+1)'(push && not_full) - (Aw+1)'(pop && not_empty);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    fill <= (Aw+1)'(QueueDepth))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (pop && !push && not_empty) |=> fill == $past(fill) - (Aw+1)'(1))
    else $error("fill count wrong on pop");
  assert property (@(posedge clk) disable iff (rst)
    (push && not_full && !pop) |=> not_empty)
    else $error("push lost");
endmodule

// ===== src/tpph_back.sv =====
// ---------------------------------------------------------------------------
// tpph_back: pedestal divider and histogram updater
// Clears the histogram after reset, then runs one job at a time; traces get
// radix-2 division, excursion choice, bin read-modify-write, result out.
// ---------------------------------------------------------------------------
module tpph_back #(
  parameter int unsigned Channels = tpph_pkg::ChannelsDefault,
  parameter int unsigned HistBins = tpph_pkg::HistBinsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_pop,
  input  tpph_pkg::job_t job,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           kind,
  output logic [2:0]     out_channel,
  output logic [15:0]    pedestal,
  output logic [15:0]    extreme_value,
  output logic [16:0]    amplitude,
  output logic [31:0]    bin_count
);
  import tpph_pkg::*;

  localparam int unsigned Total = Channels * HistBins;
  localparam int unsigned Aw    = $clog2(Total);
  localparam int unsigned Bw    = $clog2(HistBins);

  be_state_t   state, state_next;
  job_t        cur;
  logic [Aw-1:0] clr_addr;
  logic [5:0]  step;
  logic [31:0] quot;
  logic [31:0] rem;
  logic [15:0] ped;
  logic [17:0] dev;
  logic [16:0] amp;
  logic [15:0] ext;
  logic        chan_ok;
  logic [Aw-1:0] addr;
  logic [Aw-1:0] hist_addr;
  logic [31:0] ram_rdata;
  logic [31:0] ram_wdata;
  logic        ram_we;
  logic [32:0] rem_sh;
  logic [31:0] cnt;
  logic [Bw-1:0] bin;
  logic [17:0] up, down;

  tpph_ram #(.Width(32), .Depth(Total)) u_ram (
    .clk(clk), .we(ram_we), .addr(hist_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign chan_ok = 32'(cur.channel) < Channels;
  assign rem_sh  = {rem, quot[31]};

  always_comb begin
    up   = {2'b00, cur.max_val} - {2'b00, ped};
    down = {2'b00, ped} - {2'b00, cur.min_val};
    if ($signed(up) > $signed(down)) begin
      dev = up;
      ext = cur.max_val;
    end else begin
      dev = down;
      ext = cur.min_val;
    end
    if (dev[17]) bin = '0;
    else if (32'(dev) > HistBins - 1) bin = Bw'(HistBins - 1);
    else bin = Bw'(dev);
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    hist_addr  = addr;
    unique case (state)
      BE_CLEAR: begin
        ram_we    = 1'b1;
        hist_addr = clr_addr;
        if (32'(clr_addr) == Total - 1) state_next = BE_IDLE;
      end
      BE_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = (job.op == OP_READ) ? BE_READ : BE_DIV;
        end
      end
      BE_DIV:   if (step == 6'd32) state_next = BE_PICK;
      BE_PICK:  state_next = BE_READ;
      BE_READ:  state_next = BE_WRITE;
      BE_WRITE: begin
        if (cur.op == OP_SAMPLE && chan_ok && ram_rdata != 32'hFFFF_FFFF) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata + 32'd1;
        end
        state_next = BE_OUT;
      end
      BE_OUT:   if (out_ready) state_next = BE_IDLE;
      default:  state_next = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BE_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == BE_CLEAR) clr_addr <= clr_addr + Aw'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BE_IDLE: begin
        cur  <= job;
        step <= '0;
        quot <= job.sum;
        rem  <= '0;
        addr <= Aw'(32'(job.channel) * HistBins + 32'(job.bin_index));
      end
      BE_DIV: begin
        if (step != 6'd32) begin
          step <= step + 6'd1;
          if (rem_sh >= {15'd0, cur.divisor}) begin
            rem  <= 32'(rem_sh - {15'd0, cur.divisor});
            quot <= {quot[30:0], 1'b1};
          end else begin
            rem  <= rem_sh[31:0];
            quot <= {quot[30:0], 1'b0};
          end
        end else begin
          ped <= (cur.divisor == '0) ? 16'd0 :
                 (quot[31:16] != '0) ? 16'hFFFF : quot[15:0];
        end
      end
      BE_PICK: begin
        amp  <= (ext == cur.max_val && $signed(up) > $signed(down)) ?
                dev[16:0] : 17'(-dev);
        pedestal      <= ped;
        extreme_value <= ext;
        addr <= Aw'(32'(cur.channel) * HistBins + 32'(bin));
      end
      BE_WRITE: begin
        kind        <= cur.op;
        out_channel <= cur.channel;
        if (cur.op == OP_READ) begin
          pedestal      <= '0;
          extreme_value <= '0;
          amplitude     <= '0;
          bin_count     <= (chan_ok && 32'(cur.bin_index) < HistBins) ? ram_rdata : 32'd0;
        end else begin
          amplitude <= amp;
          bin_count <= !chan_ok ? 32'd0 :
                       (ram_rdata == 32'hFFFF_FFFF) ? ram_rdata : ram_rdata + 32'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = state == BE_OUT;
  assign cnt       = bin_count;

  assert property (@(posedge clk) disable iff (rst)
    job_pop |-> state == BE_IDLE)
    else $error("pop outside idle");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(cnt))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == BE_CLEAR || state == BE_WRITE))
    else $error("stray ram write");
endmodule

// ===== src/trace_pedestal_peak_histogrammer_unit.sv =====
// ---------------------------------------------------------------------------
// trace_pedestal_peak_histogrammer_unit: pulse-height analyser top level
// Sample front end, job queue and histogram back end.
// ---------------------------------------------------------------------------
// Samples are taken one per cycle while the job queue has room.
// A trace end passes through the back end's 32-step divider, excursion pick,
// bin read-modify-write and output; a bin read only reads the bin and outputs.
// After reset the back end clears CHANNELS*HIST_BINS bins, one per cycle
// (32768 bins at defaults); jobs wait in the queue meanwhile.
// Reset: synchronous, active high; registers return to 256/16/16.
module trace_pedestal_peak_histogrammer_unit #(
  parameter int unsigned CHANNELS  = tpph_pkg::ChannelsDefault,
  parameter int unsigned HIST_BINS = tpph_pkg::HistBinsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // sample[15:0], bin_index[27:16], zero
  input  logic [3:0]  s_tuser,  // op[0], channel[3:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,  // pedestal, extreme_value, amplitude, bin_count, zero
  output logic [3:0]  m_tuser,  // kind[0], out_channel[3:1]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import tpph_pkg::*;

  logic [16:0] trace_length, lead_window, tail_window;
  logic        f_valid, q_ready, q_valid, q_pop;
  job_t        f_job, q_job;
  logic        kind;
  logic [2:0]  out_channel;
  logic [15:0] pedestal, extreme_value;
  logic [16:0] amplitude;
  logic [31:0] bin_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_length <= TraceLenReset;
      lead_window  <= LeadReset;
      tail_window  <= TailReset;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TRACE_LENGTH: trace_length <= cfg_data;
        REG_LEAD_WINDOW:  lead_window  <= cfg_data;
        REG_TAIL_WINDOW:  tail_window  <= cfg_data;
        default: ;
      endcase
    end
  end

  tpph_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .op(s_tuser[0]), .channel(s_tuser[3:1]), .sample(s_tdata[15:0]),
    .bin_index(s_tdata[27:16]), .trace_length(trace_length),
    .lead_window(lead_window), .tail_window(tail_window),
    .job_valid(f_valid), .job_ready(q_ready), .job(f_job)
  );

  tpph_queue u_queue (
    .clk(clk), .rst(rst), .push(f_valid), .not_full(q_ready), .wdata(f_job),
    .pop(q_pop), .not_empty(q_valid), .rdata(q_job)
  );

  tpph_back #(.Channels(CHANNELS), .HistBins(HIST_BINS)) u_back (
    .clk(clk), .rst(rst), .job_valid(q_valid), .job_pop(q_pop), .job(q_job),
    .out_valid(m_tvalid), .out_ready(m_tready), .kind(kind),
    .out_channel(out_channel), .pedestal(pedestal), .extreme_value(extreme_value),
    .amplitude(amplitude), .bin_count(bin_count)
  );

  assign m_tuser = {out_channel, kind};
  assign m_tdata = {7'd0, bin_count, amplitude, extreme_value, pedestal};
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for trace_pedestal_peak_histogrammer_unit
// Streams trace samples and bin reads through the analyser under random
// sender bursts and receiver stalls. A predictor mirrors the accumulators,
// the register file and the amplitude histograms, and every result is
// compared field by field against the oldest outstanding expectation.
// ---------------------------------------------------------------------------
module tb_top;
  import tpph_pkg::*;

  localparam int unsigned Bins      = 4096;
  localparam int          IdleLimit = 200000;
  localparam int          BeLatency = 60;
  localparam int          HoldLen   = 400;

  typedef struct packed {
    logic        kind;
    logic [2:0]  channel;
    logic [15:0] pedestal;
    logic [15:0] extreme;
    logic [16:0] amplitude;
    logic [31:0] count;
  } pulse_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // sample[15:0], bin_index[27:16], zero
  logic [3:0]  s_tuser = '0;  // op[0], channel[3:1]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;       // pedestal, extreme_value, amplitude, bin_count, zero
  logic [3:0]  m_tuser;       // kind[0], out_channel[3:1]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  trace_pedestal_peak_histogrammer_unit dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned trace_len_q = 256, lead_q = 16, tail_q = 16;
  int unsigned sample_idx, win_sum, run_max, run_min = 65500;
  int unsigned hist [int];
  int unsigned hit_bins [$];
  pulse_res_t  pending_res [$];

  int unsigned mismatches, results_seen, items_sent, traces_done;
  int          burst_left, idle_cycles;
  int          hold_reqs, hold_taken, hold_left, rx_phase;

  function automatic int unsigned hist_get(int key);
    return hist.exists(key) ? hist[key] : 0;
  endfunction

  // mirror of the analyser for one accepted item
  task automatic predict_item(op_t op, logic [2:0] ch, logic [15:0] smp, logic [11:0] bin);
    pulse_res_t  r;
    longint      s;
    int unsigned div, ped;
    int          up, down, dev, amp, b, key;
    r = '0;
    r.channel = ch;
    if (op == OP_READ) begin
      r.kind  = 1'b1;
      r.count = hist_get(ch * Bins + bin);
      pending_res.push_back(r);
      return;
    end
    if (smp > run_max) run_max = smp;
    if (smp < run_min) run_min = smp;
    if (sample_idx < lead_q || longint'(sample_idx) + tail_q >= trace_len_q) begin
      s = longint'(win_sum) + smp;
      win_sum = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    end
    if (longint'(sample_idx) + 1 < trace_len_q) begin
      sample_idx++;
      return;
    end
    div = lead_q + tail_q;
    ped = (div != 0) ? win_sum / div : 0;
    if (ped > 16'hFFFF) ped = 16'hFFFF;
    up   = int'(run_max) - int'(ped);
    down = int'(ped) - int'(run_min);
    // equal excursions go to the trough side
    if (up > down) begin
      dev = up; amp = up; r.extreme = run_max[15:0];
    end else begin
      dev = down; amp = -down; r.extreme = run_min[15:0];
    end
    b = (dev < 0) ? 0 : (dev > Bins - 1) ? Bins - 1 : dev;
    key = ch * Bins + b;
    hist[key] = (hist_get(key) == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : hist_get(key) + 1;
    hit_bins.push_back(key);
    if (hit_bins.size() > 32) void'(hit_bins.pop_front());
    r.pedestal  = ped[15:0];
    r.amplitude = amp[16:0];
    r.count     = hist[key];
    pending_res.push_back(r);
    sample_idx = 0; win_sum = 0; run_max = 0; run_min = 65500;
    traces_done++;
  endtask

  task automatic send_item(op_t op, logic [2:0] ch, logic [15:0] smp, logic [11:0] bin);
    int gap;
    bit accepted;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, bin, smp};
    s_tuser  <= {ch, op};
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = s_tready;
      @(posedge clk);
    end
    predict_item(op, ch, smp, bin);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_trace(logic [2:0] ch, int unsigned len, int unsigned base, int unsigned pk);
    int unsigned pos, v;
    pos = $urandom_range(0, len - 1);
    for (int unsigned i = 0; i < len; i++) begin
      v = base + $urandom_range(0, 15);
      if (i == pos) v = pk;
      send_item(OP_SAMPLE, ($urandom_range(0, 7) == 0) ? 3'($urandom) : ch,
                (v > 65535) ? 16'hFFFF : v[15:0], 12'($urandom));
    end
  endtask

  task automatic read_bin();
    int key;
    if (hit_bins.size() > 0 && $urandom_range(0, 3) != 0) begin
      key = hit_bins[$urandom_range(0, hit_bins.size() - 1)];
      send_item(OP_READ, 3'(key / Bins), 16'($urandom), 12'(key % Bins));
    end else begin
      send_item(OP_READ, 3'($urandom), 16'($urandom), 12'($urandom));
    end
  endtask

  // wait for every expected result, then for the back end to settle
  task automatic drain();
    if (s_tvalid) s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (BeLatency) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned len, int unsigned lead, int unsigned tail);
    reg_idx_t idx [3];
    int unsigned val [3];
    idx = '{REG_TRACE_LENGTH, REG_LEAD_WINDOW, REG_TAIL_WINDOW};
    val = '{len, lead, tail};
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i][16:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    trace_len_q = len; lead_q = lead; tail_q = tail;
  endtask

  task automatic test_directed();
    set_regs(4, 1, 1);
    send_item(OP_SAMPLE, 3'd0, 16'd0, 12'd0);
    send_item(OP_SAMPLE, 3'd0, 16'hFFFF, 12'hFFF);
    send_item(OP_SAMPLE, 3'd0, 16'd0, 12'd0);
    send_item(OP_SAMPLE, 3'd0, 16'd0, 12'd0);
    // all samples above the minimum's start value
    repeat (4) send_item(OP_SAMPLE, 3'd7, 16'hFFFF, 12'hFFF);
    // flat trace: equal excursions
    repeat (4) send_item(OP_SAMPLE, 3'd2, 16'd100, 12'd0);
    send_item(OP_READ, 3'd0, 16'hFFFF, 12'hFFF);
    send_item(OP_READ, 3'd7, 16'd0, 12'd0);
    send_item(OP_READ, 3'd2, 16'd0, 12'd0);
    set_regs(2, 0, 0);  // zero divisor
    send_item(OP_SAMPLE, 3'd3, 16'd5, 12'd0);
    send_item(OP_SAMPLE, 3'd4, 16'd300, 12'd0);  // channel of the last sample wins
    set_regs(3, 0, 65536);  // tail window covers the whole trace
    send_item(OP_SAMPLE, 3'd5, 16'd1000, 12'd0);
    send_item(OP_SAMPLE, 3'd5, 16'd2000, 12'd0);
    send_item(OP_SAMPLE, 3'd5, 16'd3000, 12'd0);
    send_item(OP_READ, 3'd4, 16'd0, 12'd300);
    send_item(OP_READ, 3'd5, 16'd0, 12'd0);
  endtask

  task automatic test_random();
    int unsigned len, lead, tail, base, pk;
    for (int ph = 0; ph < 8; ph++) begin
      len  = (ph == 0) ? 2 : $urandom_range(2, 12);
      lead = ($urandom_range(0, 5) == 0) ? 65536 : $urandom_range(0, len + 1);
      tail = ($urandom_range(0, 5) == 0) ? 65536 : $urandom_range(0, len + 1);
      set_regs(len, lead, tail);
      while (items_sent < 20 + (ph + 1) * 50) begin
        case ($urandom_range(0, 5))
          0: read_bin();
          1: begin
            // noise trace over the full sample range
            for (int unsigned i = 0; i < len; i++)
              send_item(OP_SAMPLE, 3'($urandom), 16'($urandom), 12'($urandom));
          end
          default: begin
            base = $urandom_range(0, 65000);
            pk = ($urandom_range(0, 1) != 0) ? base + $urandom_range(0, 5000)
                                             : base - $urandom_range(0, base);
            send_trace(3'($urandom), len, base, pk);
          end
        endcase
      end
    end
  endtask

  task automatic test_backpressure();
    set_regs(2, 1, 1);
    hold_reqs++;
    repeat (30) read_bin();
    repeat (10) send_trace(3'($urandom), 2, $urandom_range(0, 60000), $urandom_range(0, 65535));
  endtask

  task automatic test_longest_trace();
    set_regs(40, 65536, 65536);
    for (int unsigned i = 0; i < 40; i++)
      send_item(OP_SAMPLE, 3'd6, 16'($urandom_range(0, 255) + (i == 25 ? 30000 : 0)),
                12'($urandom));
    read_bin();
    set_regs(32, 4, 4);
    send_trace(3'd1, 32, 1000, 900);
  endtask

  // receiver: long fully-ready stretches alternate with random stalls
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_reqs) begin
      hold_taken <= hold_reqs;
      hold_left  <= HoldLen;
      m_tready   <= 1'b0;
    end else if (rx_phase[6]) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // handshake values are stable at the falling edge, ahead of the accepting edge
  always @(negedge clk) begin
    pulse_res_t got, want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no item moved for %0d cycles", IdleLimit);
        $display("Some tests failed");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tuser[3:1], m_tdata[15:0], m_tdata[31:16], m_tdata[48:32],
               m_tdata[80:49]};
        results_seen++;
        if (pending_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", got);
        end else begin
          want = pending_res.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: kind %0d/%0d ch %0d/%0d ped %0d/%0d ext %0d/%0d amp %0d/%0d cnt %0d/%0d (exp/got)",
                       want.kind, got.kind, want.channel, got.channel, want.pedestal,
                       got.pedestal, want.extreme, got.extreme, $signed(want.amplitude),
                       $signed(got.amplitude), want.count, got.count);
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_longest_trace();
    drain();
    $display("Covered %0d items and %0d traces, %0d results checked, over trace lengths 2..40",
             items_sent, traces_done, results_seen);
    $display("with zero, short and oversized windows, bin reads and a long receiver hold-off.");
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_res.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
